// ----- hdl/osset_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered selection set package
// Sizes, command codes, controller states, the cell control bundle and a
// prefix OR helper.
package osset_pkg;

   localparam int CAPACITY = 64;
   localparam int ID_BITS  = 12;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int CMD_BITS = 3;
   localparam int REQ_ID_BITS = 12;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_QUERY  = 3'd0,
      CMD_ADD    = 3'd1,
      CMD_REMOVE = 3'd2,
      CMD_TOGGLE = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD
   } state_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic               cmp_en;
      logic               shift_en;
      logic               append_en;
      logic [ID_BITS-1:0] id;
   } cell_ctl_type;

   // Inclusive prefix OR: bit i is set when any bit at or below i is set.
   function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] v);
      logic [CAPACITY-1:0] r;
      r = v;
      for (int s = 1; s < CAPACITY; s = s * 2) begin
         r = r | (r << s);
      end
      return r;
   endfunction

endpackage

// ----- hdl/osset_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered selection set cell
// Holds one stored identifier, compares it with the broadcast identifier and
// takes its upper neighbor's value when an entry at or below it is removed.
// ----------------------------------------------------------------------------
module osset_cell (
   input  logic                                clock,
   input  osset_pkg::cell_ctl_type             ctl,
   input  logic                                cell_valid,
   input  logic                                cell_tail,
   input  logic                                shift_sel,
   input  logic [osset_pkg::ID_BITS-1:0]       next_entry,
   output logic [osset_pkg::ID_BITS-1:0]       entry,
   output logic                                match
);

   logic [osset_pkg::ID_BITS-1:0] entry_ff;
   logic [osset_pkg::ID_BITS-1:0] entry_in;
   logic                          match_ff;
   logic                          match_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift_en && shift_sel) begin
         entry_in = next_entry;
      end else if (ctl.append_en && cell_tail) begin
         entry_in = ctl.id;
      end
      match_in = match_ff;
      if (ctl.cmp_en) begin
         match_in = cell_valid && (entry_ff == ctl.id);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ----- hdl/ordered_selection_set.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered selection set
// A set of distinct identifiers kept in insertion order in a chain of cells,
// with query, add, remove with compaction, toggle and clear commands.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+---------------------------------
//   req     | in        | req_valid/req_stall  | req_cmd, req_item_id
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_is_member, rsp_entry_count,
//           |           |                      | rsp_changed, rsp_full_reject
//
// Each transaction steps through the controller states in order: idle
// captures the request, compare has every cell compare its entry with the
// identifier, and update changes the cells and loads the result register.
// The controller handles one transaction at a time, so the block takes no
// new request until the last one has left the update state. A stalled result
// holds the update state until the result register frees up. Synchronous
// reset empties the set at once; the stored identifiers are not cleared.
//
module ordered_selection_set (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [osset_pkg::CMD_BITS-1:0]        req_cmd,
   input  logic [osset_pkg::REQ_ID_BITS-1:0]     req_item_id,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_is_member,
   output logic [osset_pkg::CNT_BITS-1:0]        rsp_entry_count,
   output logic                                  rsp_changed,
   output logic                                  rsp_full_reject
);

   localparam int N = osset_pkg::CAPACITY;

   // Controller state and the captured transaction.
   osset_pkg::state_type              state_ff, state_in;
   logic [osset_pkg::CNT_BITS-1:0]    count_ff, count_in;
   osset_pkg::cmd_type                cmd_ff;
   logic [osset_pkg::ID_BITS-1:0]     id_ff;

   // Result register, which lets the next request in while a result waits.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              member_ff, member_in;
   logic                              changed_ff, changed_in;
   logic                              reject_ff, reject_in;

   // Chain signals.
   osset_pkg::cell_ctl_type           ctl;
   logic [N-1:0]                      match_vec;
   logic [N-1:0]                      valid_vec;
   logic [N-1:0]                      tail_vec;
   logic [N-1:0]                      shift_vec;
   logic [osset_pkg::ID_BITS-1:0]     entry_vec [N];

   logic                              accept;
   logic                              commit;
   logic                              present;
   logic                              full;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != osset_pkg::ST_IDLE);
   assign present   = |match_vec;
   assign full      = (count_ff == osset_pkg::CNT_BITS'(N));

   // A remove moves every entry above the matching cell down by one.
   assign shift_vec = osset_pkg::prefix_or(match_vec);

   // The update cycle completes once the result register can take the result.
   assign commit = (state_ff == osset_pkg::ST_UPD) && (!rsp_valid_ff || !rsp_stall);

   // Capture of the request. The identifier keeps only its low ID_BITS bits.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= osset_pkg::cmd_type'(req_cmd);
         id_ff  <= req_item_id[osset_pkg::ID_BITS-1:0];
      end
   end

   // Next state, count update, cell control and result.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      member_in     = member_ff;
      changed_in    = changed_ff;
      reject_in     = reject_ff;
      ctl.cmp_en    = 1'b0;
      ctl.shift_en  = 1'b0;
      ctl.append_en = 1'b0;
      ctl.id        = id_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         osset_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = osset_pkg::ST_CMP;
            end
         end
         osset_pkg::ST_CMP: begin
            // Every cell compares its entry with the identifier in parallel.
            ctl.cmp_en = 1'b1;
            state_in   = osset_pkg::ST_UPD;
         end
         osset_pkg::ST_UPD: begin
            if (commit) begin
               state_in     = osset_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               member_in    = present;
               changed_in   = 1'b0;
               reject_in    = 1'b0;
               unique case (cmd_ff)
                  osset_pkg::CMD_ADD: begin
                     if (!present) begin
                        if (full) begin
                           reject_in = 1'b1;
                        end else begin
                           ctl.append_en = 1'b1;
                           count_in      = count_ff + 1'b1;
                           member_in     = 1'b1;
                           changed_in    = 1'b1;
                        end
                     end
                  end
                  osset_pkg::CMD_REMOVE: begin
                     member_in = 1'b0;
                     if (present) begin
                        ctl.shift_en = 1'b1;
                        count_in     = count_ff - 1'b1;
                        changed_in   = 1'b1;
                     end
                  end
                  osset_pkg::CMD_TOGGLE: begin
                     // A toggle always reports a change, even when refused.
                     changed_in = 1'b1;
                     if (present) begin
                        ctl.shift_en = 1'b1;
                        count_in     = count_ff - 1'b1;
                        member_in    = 1'b0;
                     end else if (full) begin
                        reject_in = 1'b1;
                     end else begin
                        ctl.append_en = 1'b1;
                        count_in      = count_ff + 1'b1;
                        member_in     = 1'b1;
                     end
                  end
                  osset_pkg::CMD_CLEAR: begin
                     count_in   = '0;
                     member_in  = 1'b0;
                     changed_in = 1'b1;
                  end
                  default: begin
                     // Query and the unused codes leave the set unchanged.
                  end
               endcase
            end
         end
         default: begin
            state_in = osset_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= osset_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      member_ff  <= member_in;
      changed_ff <= changed_in;
      reject_ff  <= reject_in;
   end

   // The chain. Cell i is occupied below the count and is the append slot at
   // the count. The top cell has no upper neighbor and keeps its own value.
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [osset_pkg::ID_BITS-1:0] upper;

      assign valid_vec[i] = (osset_pkg::CNT_BITS'(i) < count_ff);
      assign tail_vec[i]  = (osset_pkg::CNT_BITS'(i) == count_ff);

      if (i == N - 1) begin : g_top
         assign upper = entry_vec[i];
      end else begin : g_mid
         assign upper = entry_vec[i+1];
      end

      osset_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_valid (valid_vec[i]),
         .cell_tail  (tail_vec[i]),
         .shift_sel  (shift_vec[i]),
         .next_entry (upper),
         .entry      (entry_vec[i]),
         .match      (match_vec[i])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_member   = member_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_changed     = changed_ff;
   assign rsp_full_reject = reject_ff;

   // The count never goes past the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= osset_pkg::CNT_BITS'(N))
      else $error("entry count exceeds capacity");

   // Stored identifiers are distinct, so at most one occupied cell matches.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == osset_pkg::ST_UPD) |-> $onehot0(match_vec))
      else $error("more than one cell matches the identifier");

   // A result only appears at the end of an update cycle.
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == osset_pkg::ST_UPD))
      else $error("result raised outside an update");

   // A compacting remove drops exactly one entry.
   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      ctl.shift_en |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("remove did not decrement the count");

   // An append only happens with room left.
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      ctl.append_en |-> !full)
      else $error("append into a full set");

endmodule
